>>> src/watm_pkg.sv
// Package: types, codes and sizes shared by the weekly alarm table matcher.
package watm_pkg;

  localparam int NUM_ALARMS = 32;
  localparam int ID_W       = 5;
  localparam int ADDR_W     = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CNT_W      = $clog2(NUM_ALARMS + 1);

  localparam logic [1:0] OP_HIGH = 2'd0;
  localparam logic [1:0] OP_LOW  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_TIME = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TIME  = 2'd1;
  localparam logic [1:0] ST_PARAM = 2'd2;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [7:0] MIN_NONE   = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] word;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [2:0]  cur_weekday;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [4:0] fired_id;
    logic [6:0] fired_tone;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [6:0] tone;
    logic [6:0] mask;
    logic       rpt;
    logic [4:0] hour;
    logic [5:0] minute;
  } setting_t;

  localparam int SET_W = $bits(setting_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic cap;
    logic scan_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_go;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

>>> src/weekly_alarm_table_matcher_core.sv
// Top level of the weekly alarm table matcher: controller plus datapath.
// Ops 0 to 2 and a repeated minute go from S_IDLE to S_DONE, which registers their beat once the output is free.
// A new-minute time sample reads the settings RAM one entry a cycle while no held hit waits
// on a stalled output, and gives its final beat in S_DONE once the output is free.
// One item at a time: a new item is taken only back in S_IDLE, after the last one's final beat.
// Reset clears control, enable and fired flags; settings RAM stays undefined, no clear pass.
module weekly_alarm_table_matcher_core
  import watm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  watm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  watm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.status == ST_OK)
    else $error("fired beat with non-ok status");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken while a non-final beat is pending");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken before first finished");
`endif

endmodule

>>> src/watm_ram.sv
// Generic single-port-write RAM with registered read.
module watm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/watm_ctrl.sv
// Controller: sequences capture, table scan and result hand-off.
module watm_ctrl
  import watm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.scan_go ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.cap  = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
      end
      S_DONE: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> src/watm_dp.sv
// Datapath: alarm flags, settings RAM, scan pipeline and result register.
module watm_dp
  import watm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  in_t                   cap_q;
  logic [15:0]           pend_hw_q, pend_hw_d;
  logic [7:0]            last_min_q, last_min_d;
  logic [NUM_ALARMS-1:0] en_q, en_d;
  logic [NUM_ALARMS-1:0] fo_q, fo_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  chk_v_q, chk_v_d;
  logic [ID_W-1:0]       chk_idx_q;
  logic                  held_v_q, held_v_d;
  logic [ID_W-1:0]       held_id_q;
  logic [6:0]            held_tone_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  setting_t              rd_set;
  setting_t              wr_set;
  logic [SET_W-1:0]      rdata;
  logic                  ram_we;
  logic                  issue;
  logic                  hit;
  logic                  take_hit;
  logic                  pipe_stall;
  logic                  out_free;
  logic [7:0]            mask8;
  logic [ID_W-1:0]       c_id;
  logic [4:0]            c_hour;
  logic [5:0]            c_min;
  logic [7:0]            del_id;
  logic                  time_bad;
  logic                  id_bad;
  logic                  del_bad;
  logic [1:0]            status;

  assign out_free = !out_valid_q || !out_stall_i;

  // high word fields
  assign c_id     = pend_hw_q[15:11];
  assign c_hour   = pend_hw_q[10:6];
  assign c_min    = pend_hw_q[5:0];
  assign del_id   = cap_q.word[7:0];
  assign time_bad = (c_hour > MAX_HOUR) || (c_min > MAX_MINUTE);
  assign id_bad   = 32'(c_id) >= NUM_ALARMS;
  assign del_bad  = 32'(del_id) >= NUM_ALARMS;

  always_comb begin
    case (cap_q.op)
      OP_LOW:  status = time_bad ? ST_TIME : (id_bad ? ST_PARAM : ST_OK);
      OP_DEL:  status = del_bad ? ST_PARAM : ST_OK;
      default: status = ST_OK;
    endcase
  end

  assign wr_set = '{tone:   cap_q.word[15:9],
                    mask:   cap_q.word[8:2],
                    rpt:    cap_q.word[1],
                    hour:   c_hour,
                    minute: c_min};
  assign ram_we = cmd_i.finish && (cap_q.op == OP_LOW) && !time_bad && !id_bad;

  // scan match on the entry that the last issued read returned
  assign rd_set = setting_t'(rdata);
  assign mask8  = {1'b0, rd_set.mask};
  assign hit    = chk_v_q && en_q[chk_idx_q] &&
                  (rd_set.hour == cap_q.cur_hour) &&
                  (rd_set.minute == cap_q.cur_minute) &&
                  mask8[cap_q.cur_weekday] &&
                  (rd_set.rpt || !fo_q[chk_idx_q]);

  assign pipe_stall = hit && held_v_q && !out_free;
  assign issue      = cmd_i.scan_en && !pipe_stall && (idx_q != CNT_W'(NUM_ALARMS));
  assign take_hit   = cmd_i.scan_en && hit && !pipe_stall;

  watm_ram #(
    .WIDTH (SET_W),
    .DEPTH (NUM_ALARMS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_id[ADDR_W-1:0]),
    .wdata_i (wr_set),
    .re_i    (issue),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    pend_hw_d   = pend_hw_q;
    last_min_d  = last_min_q;
    en_d        = en_q;
    fo_d        = fo_q;
    idx_d       = idx_q;
    chk_v_d     = chk_v_q;
    held_v_d    = held_v_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (cmd_i.cap) begin
      idx_d   = '0;
      chk_v_d = 1'b0;
      if (sts_o.scan_go) begin
        last_min_d = {2'b00, in_data_i.cur_minute};
      end
    end

    if (cmd_i.scan_en && !pipe_stall) begin
      chk_v_d = issue;
      if (issue) begin
        idx_d = idx_q + CNT_W'(1);
      end
    end

    if (take_hit) begin
      held_v_d = 1'b1;
      if (!rd_set.rpt) begin
        fo_d[chk_idx_q] = 1'b1;
      end
      if (held_v_q) begin
        out_valid_d = 1'b1;
        out_d       = '{status: ST_OK, fired: 1'b1, fired_id: held_id_q,
                        fired_tone: held_tone_q, last: 1'b0};
      end
    end

    if (cmd_i.finish) begin
      held_v_d    = 1'b0;
      out_valid_d = 1'b1;
      if (cap_q.op == OP_TIME && held_v_q) begin
        out_d = '{status: ST_OK, fired: 1'b1, fired_id: held_id_q,
                  fired_tone: held_tone_q, last: 1'b1};
      end else begin
        out_d = '{status: status, fired: 1'b0, fired_id: '0,
                  fired_tone: '0, last: 1'b1};
      end
      case (cap_q.op)
        OP_HIGH: pend_hw_d = cap_q.word;
        OP_LOW: begin
          if (ram_we) begin
            en_d[c_id] = cap_q.word[0];
            fo_d[c_id] = 1'b0;
          end
        end
        OP_DEL: begin
          if (!del_bad) begin
            en_d[del_id[ID_W-1:0]] = 1'b0;
            fo_d[del_id[ID_W-1:0]] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_hw_q   <= '0;
      last_min_q  <= MIN_NONE;
      en_q        <= '0;
      fo_q        <= '0;
      idx_q       <= '0;
      chk_v_q     <= 1'b0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_hw_q   <= pend_hw_d;
      last_min_q  <= last_min_d;
      en_q        <= en_d;
      fo_q        <= fo_d;
      idx_q       <= idx_d;
      chk_v_q     <= chk_v_d;
      held_v_q    <= held_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.cap) begin
      cap_q <= in_data_i;
    end
    if (issue) begin
      chk_idx_q <= idx_q[ID_W-1:0];
    end
    if (take_hit) begin
      held_id_q   <= chk_idx_q;
      held_tone_q <= rd_set.tone;
    end
  end

  assign sts_o.scan_go   = (in_data_i.op == OP_TIME) &&
                           ({2'b00, in_data_i.cur_minute} != last_min_q);
  assign sts_o.scan_done = (idx_q == CNT_W'(NUM_ALARMS)) && !chk_v_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
